@@ rtl/bb3_pkg.sv @@
// Shared types and constants of the 3x3 box blur block.
// No dependencies; the RTL refers to it by scoped names, the testbench imports it.
package bb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W  = $clog2(MAX_WIDTH);        // column index
    localparam int WID_W  = 11;                       // image_width register
    localparam int HGT_W  = 13;                       // image_height register
    localparam int IROW_W = 13;                       // input row, may run past height
    localparam int OROW_W = $clog2(MAX_HEIGHT);       // output row
    localparam int CFG_W  = 13;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(512);
    localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(512);

    // floor(s / 9) = (s * 3641) >> 15 for every s up to 9 * 255
    localparam int SUM_W      = 12;
    localparam int DIV9_MUL   = 3641;
    localparam int DIV9_SHIFT = 15;
    localparam int PROD_W     = 24;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam int OUT_DEPTH = 4;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = OPTR_W + 1;

    // channel 0 in bits 7:0, channel 1 in 15:8, channel 2 in 23:16
    typedef logic [23:0] pixel_t;

    // one column of the line store: two rows above the incoming one
    typedef struct packed {
        pixel_t upper;
        pixel_t lower;
    } line_t;

    // item handed from the front part to the back part
    typedef struct packed {
        pixel_t up;
        pixel_t lo;
        pixel_t pix;
        logic   has_out;
        logic   interior;
        logic   last;
    } work_t;

    typedef struct packed {
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
        logic       last;
    } result_t;

endpackage

@@ rtl/bb3_front.sv @@
// Front part: input handshake, frame position counters, item classification
// and the two-row line store. Depends on bb3_pkg.
module bb3_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic                      cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0] cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic                      operation,
    input  logic [7:0]                chan0_in,
    input  logic [7:0]                chan1_in,
    input  logic [7:0]                chan2_in,
    input  logic [bb3_pkg::QCNT_W-1:0] q_count,
    output logic                      q_push,
    output bb3_pkg::work_t            q_item
);

    logic [bb3_pkg::WID_W-1:0]  w_reg, w_next;
    logic [bb3_pkg::HGT_W-1:0]  h_reg, h_next;
    logic [bb3_pkg::COL_W-1:0]  in_col_reg, in_col_next;
    logic [bb3_pkg::IROW_W-1:0] in_row_reg, in_row_next;
    logic [bb3_pkg::COL_W-1:0]  out_col_reg, out_col_next;
    logic [bb3_pkg::OROW_W-1:0] out_row_reg, out_row_next;

    logic                      f1_valid_reg;
    logic [bb3_pkg::COL_W-1:0] f1_col_reg;
    bb3_pkg::pixel_t           f1_pix_reg;
    logic                      f1_has_out_reg;
    logic                      f1_interior_reg;
    logic                      f1_last_reg;
    bb3_pkg::line_t            rd_reg;

    bb3_pkg::line_t line_mem [bb3_pkg::MAX_WIDTH];

    logic            accept;
    logic            frame_done;
    logic            take;
    logic            col_wrap;
    logic            has_out;
    logic            interior;
    logic            last;
    logic            out_col_wrap;
    bb3_pkg::pixel_t pix;

    function automatic logic [bb3_pkg::WID_W-1:0] clamp_width(
        input logic [bb3_pkg::WID_W-1:0] v
    );
        logic [bb3_pkg::WID_W-1:0] r;
        r = v;
        if (v < bb3_pkg::WID_W'(3))
            r = bb3_pkg::WID_W'(3);
        else if (v > bb3_pkg::WID_W'(bb3_pkg::MAX_WIDTH))
            r = bb3_pkg::WID_W'(bb3_pkg::MAX_WIDTH);
        return r;
    endfunction

    function automatic logic [bb3_pkg::HGT_W-1:0] clamp_height(
        input logic [bb3_pkg::HGT_W-1:0] v
    );
        logic [bb3_pkg::HGT_W-1:0] r;
        r = v;
        if (v < bb3_pkg::HGT_W'(3))
            r = bb3_pkg::HGT_W'(3);
        else if (v > bb3_pkg::HGT_W'(bb3_pkg::MAX_HEIGHT))
            r = bb3_pkg::HGT_W'(bb3_pkg::MAX_HEIGHT);
        return r;
    endfunction

    // room for the item in F1 and the one about to be taken
    assign full   = ({1'b0, q_count} + {{bb3_pkg::QCNT_W{1'b0}}, f1_valid_reg})
                    >= (bb3_pkg::QCNT_W+1)'(bb3_pkg::QUEUE_DEPTH);
    assign accept = push && !full;

    assign frame_done = {1'b0, in_row_reg} >= (bb3_pkg::IROW_W+1)'(h_reg);
    assign take       = accept && ((operation == bb3_pkg::OP_DRAIN) ? frame_done : !frame_done);
    assign col_wrap   = ({1'b0, in_col_reg} + bb3_pkg::WID_W'(1)) >= w_reg;

    // first W+1 items of a frame only fill the window
    assign has_out = !((in_row_reg == '0) ||
                       (in_row_reg == bb3_pkg::IROW_W'(1) && in_col_reg == '0));

    assign interior = (out_row_reg != '0) &&
                      (({1'b0, out_row_reg} + bb3_pkg::HGT_W'(2)) <= h_reg) &&
                      (out_col_reg != '0) &&
                      (({1'b0, out_col_reg} + bb3_pkg::WID_W'(2)) <= w_reg);
    assign out_col_wrap = ({1'b0, out_col_reg} + bb3_pkg::WID_W'(1)) >= w_reg;
    assign last = out_col_wrap &&
                  (({1'b0, out_row_reg} + bb3_pkg::HGT_W'(1)) >= h_reg);

    assign pix = (operation == bb3_pkg::OP_PIXEL) ? {chan2_in, chan1_in, chan0_in} : '0;

    always_comb
    begin
        w_next       = w_reg;
        h_next       = h_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_write)
        begin
            if (cfg_index == bb3_pkg::REG_WIDTH)
                w_next = clamp_width(cfg_data[bb3_pkg::WID_W-1:0]);
            else
                h_next = clamp_height(cfg_data[bb3_pkg::HGT_W-1:0]);
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (take)
        begin
            if (col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + bb3_pkg::IROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + bb3_pkg::COL_W'(1);
            end
            if (has_out)
            begin
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + bb3_pkg::OROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + bb3_pkg::COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg        <= bb3_pkg::WIDTH_RESET;
            h_reg        <= bb3_pkg::HEIGHT_RESET;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            w_reg        <= w_next;
            h_reg        <= h_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            f1_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f1_col_reg      <= in_col_reg;
            f1_pix_reg      <= pix;
            f1_has_out_reg  <= has_out;
            f1_interior_reg <= interior;
            f1_last_reg     <= last;
        end
    end

    // line store: read now, write back shifted in the next cycle.
    // The next read of the same column is at least two items away.
    always_ff @(posedge clk)
    begin
        if (take)
            rd_reg <= line_mem[in_col_reg];
        if (f1_valid_reg)
            line_mem[f1_col_reg] <= '{upper: rd_reg.lower, lower: f1_pix_reg};
    end

    assign q_push = f1_valid_reg;
    always_comb
    begin
        q_item          = '0;
        q_item.up       = rd_reg.upper;
        q_item.lo       = rd_reg.lower;
        q_item.pix      = f1_pix_reg;
        q_item.has_out  = f1_has_out_reg;
        q_item.interior = f1_interior_reg;
        q_item.last     = f1_last_reg;
    end

endmodule

@@ rtl/bb3_queue.sv @@
// Short queue of classified items between the front and back parts.
// Depends on bb3_pkg.
module bb3_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  bb3_pkg::work_t             push_item,
    input  logic                       pop,
    output logic                       empty,
    output bb3_pkg::work_t             head,
    output logic [bb3_pkg::QCNT_W-1:0] count
);

    bb3_pkg::work_t                store [bb3_pkg::QUEUE_DEPTH];
    logic [bb3_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [bb3_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [bb3_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          do_pop;

    assign empty  = (count_reg == '0);
    assign do_pop = pop && !empty;
    assign head   = store[rd_ptr_reg];
    assign count  = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + bb3_pkg::QCNT_W'(1);
        else if (!push && do_pop)
            count_next = count_reg - bb3_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + bb3_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + bb3_pkg::QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= push_item;
    end

endmodule

@@ rtl/bb3_back.sv @@
// Back part: 3x3 window, channel sums, divide by nine, border select and
// the result queue. Depends on bb3_pkg.
module bb3_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  bb3_pkg::work_t       q_head,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output bb3_pkg::result_t     result
);

    bb3_pkg::pixel_t win_reg [9];

    logic b1_valid_reg;
    logic b1_interior_reg;
    logic b1_last_reg;

    logic                        b2_valid_reg;
    logic                        b2_interior_reg;
    logic                        b2_last_reg;
    logic [bb3_pkg::SUM_W-1:0]   b2_sum_reg [3];
    bb3_pkg::pixel_t             b2_center_reg;

    bb3_pkg::result_t            out_store [bb3_pkg::OUT_DEPTH];
    logic [bb3_pkg::OPTR_W-1:0]  o_wr_ptr_reg;
    logic [bb3_pkg::OPTR_W-1:0]  o_rd_ptr_reg;
    logic [bb3_pkg::OCNT_W-1:0]  o_count_reg, o_count_next;

    logic [bb3_pkg::SUM_W-1:0]   sum [3];
    logic [bb3_pkg::PROD_W-1:0]  prod [3];
    logic [bb3_pkg::OCNT_W:0]    credit_used;
    logic                        o_pop;
    bb3_pkg::result_t            res;

    // results already queued plus those still in the two stages
    assign credit_used = {1'b0, o_count_reg}
                       + {{bb3_pkg::OCNT_W{1'b0}}, b1_valid_reg}
                       + {{bb3_pkg::OCNT_W{1'b0}}, b2_valid_reg};
    assign q_pop = !q_empty && (credit_used < (bb3_pkg::OCNT_W+1)'(bb3_pkg::OUT_DEPTH));

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = '0;
            for (int k = 0; k < 9; k++)
                sum[ch] = sum[ch] + bb3_pkg::SUM_W'(win_reg[k][8*ch +: 8]);
        end
    end

    // window shift: left column drops out, new column on the right
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= q_head.up;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= q_head.lo;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= q_head.pix;
            b1_interior_reg <= q_head.interior;
            b1_last_reg     <= q_head.last;
        end
        b2_interior_reg <= b1_interior_reg;
        b2_last_reg     <= b1_last_reg;
        b2_center_reg   <= win_reg[4];
        for (int ch = 0; ch < 3; ch++)
            b2_sum_reg[ch] <= sum[ch];
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
            prod[ch] = bb3_pkg::PROD_W'(b2_sum_reg[ch]) * bb3_pkg::PROD_W'(bb3_pkg::DIV9_MUL);
    end

    always_comb
    begin
        res      = '0;
        res.last = b2_last_reg;
        if (b2_interior_reg)
        begin
            res.chan0 = prod[0][bb3_pkg::DIV9_SHIFT +: 8];
            res.chan1 = prod[1][bb3_pkg::DIV9_SHIFT +: 8];
            res.chan2 = prod[2][bb3_pkg::DIV9_SHIFT +: 8];
        end
        else
        begin
            res.chan0 = b2_center_reg[7:0];
            res.chan1 = b2_center_reg[15:8];
            res.chan2 = b2_center_reg[23:16];
        end
    end

    assign empty  = (o_count_reg == '0);
    assign o_pop  = pop && !empty;
    assign result = out_store[o_rd_ptr_reg];

    always_comb
    begin
        o_count_next = o_count_reg;
        if (b2_valid_reg && !o_pop)
            o_count_next = o_count_reg + bb3_pkg::OCNT_W'(1);
        else if (!b2_valid_reg && o_pop)
            o_count_next = o_count_reg - bb3_pkg::OCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            o_wr_ptr_reg <= '0;
            o_rd_ptr_reg <= '0;
            o_count_reg  <= '0;
        end
        else
        begin
            b1_valid_reg <= q_pop && q_head.has_out;
            b2_valid_reg <= b1_valid_reg;
            if (b2_valid_reg)
                o_wr_ptr_reg <= o_wr_ptr_reg + bb3_pkg::OPTR_W'(1);
            if (o_pop)
                o_rd_ptr_reg <= o_rd_ptr_reg + bb3_pkg::OPTR_W'(1);
            o_count_reg <= o_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b2_valid_reg)
            out_store[o_wr_ptr_reg] <= res;
    end

endmodule

@@ rtl/box_blur_3x3_rgb.sv @@
// Top level of the 3x3 mean blur for 8-bit three-channel pixels.
// Depends on bb3_pkg, bb3_front, bb3_queue and bb3_back.
//
// Usage:
//   Input queue side: drive operation/chan*_in and raise push; the item is
//   taken on a clock edge with push high and full low. operation selects a
//   pixel or a drain tick; W+1 drain ticks after the last pixel of a frame
//   flush the last row.
//   Result queue side: while empty is low the oldest result sits on
//   chan*_out/frame_last; pop high on a clock edge takes it.
//   Config: cfg_write with cfg_index (0 = image_width, 1 = image_height)
//   writes cfg_data; sizes are clamped to 3..1024 and 3..4096 and the frame
//   position restarts. Write only while the block is idle.
// Timing:
//   One item per clock sustained while full stays low. A result passes
//   the line store read, queue, window and sum/divide registers into the
//   result queue; the output pixel trails its input position by W+1 items.
// Reset: clears the position counters, both queues and the pipeline valid
//   bits; sizes return to 512 x 512. Line store contents stay undefined.
// Stall: if pop stays low the 4-entry result queue fills, the back part
//   stops taking from the 4-entry middle queue, and full rises once that
//   one is taken up too; nothing is lost.
module box_blur_3x3_rgb (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_write,
    input  logic                      cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0] cfg_data,
    // input items
    input  logic                      push,
    output logic                      full,
    input  logic                      operation,
    input  logic [7:0]                chan0_in,
    input  logic [7:0]                chan1_in,
    input  logic [7:0]                chan2_in,
    // result items
    output logic                      empty,
    input  logic                      pop,
    output logic [7:0]                chan0_out,
    output logic [7:0]                chan1_out,
    output logic [7:0]                chan2_out,
    output logic                      frame_last
);

    // front to queue
    logic                        q_push;
    bb3_pkg::work_t              q_push_item;
    logic [bb3_pkg::QCNT_W-1:0]  q_count;
    // queue to back
    logic                        q_pop;
    logic                        q_empty;
    bb3_pkg::work_t              q_head;
    bb3_pkg::result_t            result;

    // classification, position counters and the line store
    bb3_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .operation (operation),
        .chan0_in  (chan0_in),
        .chan1_in  (chan1_in),
        .chan2_in  (chan2_in),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_item    (q_push_item)
    );

    // lets the front keep taking pixels while the back waits on the output
    bb3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head),
        .count     (q_count)
    );

    // window, arithmetic and the result queue
    bb3_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    assign chan0_out  = result.chan0;
    assign chan1_out  = result.chan1;
    assign chan2_out  = result.chan2;
    assign frame_last = result.last;

endmodule

@@ dv/box_blur_3x3_rgb_tb.sv @@
// Self-checking testbench for box_blur_3x3_rgb: a line-buffered 3x3 mean blur
// predictor in a small scoreboard class, queue-style drivers and a watchdog.
// Depends on bb3_pkg and the box_blur_3x3_rgb RTL.
module box_blur_3x3_rgb_tb;
    import bb3_pkg::*;

    localparam int RANDOM_ITEMS  = 560;   // counted items in the random part
    localparam int SETTLE_CYCLES = 8;     // lets the pipeline run dry after the last expected pixel
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int STALL_LIMIT   = 2000;  // cycles with no item moving on either side
    localparam int END_CYCLES    = 20;

    // byte patterns for the second directed frame: walking halves and nibbles
    localparam logic [7:0] PATTERN [9] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F,
                                          8'hF0, 8'h33, 8'hCC, 8'h01};

    // Blur predictor and store of expected output pixels.
    // Mirrors the two line stores, the 3x3 window and both position counters.
    class blur_checker;
        pixel_t                line_up [MAX_WIDTH];
        pixel_t                line_lo [MAX_WIDTH];
        pixel_t                win [9];
        int unsigned           in_col, in_row, out_col, out_row;
        logic [WID_W-1:0]      width_reg;
        logic [HGT_W-1:0]      height_reg;
        result_t               expected_pixels [$];
        int unsigned           errors;

        function new();
            foreach (line_up[i])
            begin
                line_up[i] = '0;
                line_lo[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            errors     = 0;
            restart();
        endfunction

        static function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v < 3)
                return 3;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void restart();
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        // a write restarts the frame; line stores keep their contents
        function void write_reg(logic idx, logic [CFG_W-1:0] d);
            if (idx == REG_WIDTH)
                width_reg = d[WID_W-1:0];
            else
                height_reg = d[HGT_W-1:0];
            restart();
        endfunction

        // one accepted input item; queues the output pixel it releases, if any
        function void take_item(logic op, logic [7:0] c0, logic [7:0] c1,
                                logic [7:0] c2);
            int unsigned w, h, n, c, prv;
            int unsigned sum [3];
            pixel_t      pix, centre, up, lo;
            result_t     r;
            bit          inner;
            w = clamp_dim(width_reg, MAX_WIDTH);
            h = clamp_dim(height_reg, MAX_HEIGHT);
            n = in_row * w + in_col;
            // pixel past the frame end, or drain tick too early: no effect
            if (op == OP_PIXEL && n >= w * h)
                return;
            if (op == OP_DRAIN && n < w * h)
                return;
            pix = (op == OP_PIXEL) ? {c2, c1, c0} : '0;
            c   = (in_col >= w) ? 0 : in_col;
            prv = (c == 0) ? w - 1 : c - 1;
            centre = line_up[prv];
            up = line_up[c];
            lo = line_lo[c];
            line_up[c] = lo;
            line_lo[c] = pix;
            for (int k = 0; k < 3; k++)
            begin
                win[k * 3]     = win[k * 3 + 1];
                win[k * 3 + 1] = win[k * 3 + 2];
            end
            win[2] = up;
            win[5] = lo;
            win[8] = pix;
            if (c + 1 >= w)
            begin
                in_col = 0;
                in_row++;
            end
            else
                in_col = c + 1;
            // output trails the input by one row and one pixel
            if (n < w + 1)
                return;
            inner = out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w;
            if (inner)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    sum[ch] = 0;
                    for (int k = 0; k < 9; k++)
                        sum[ch] += win[k][8 * ch +: 8];
                end
                r.chan0 = 8'(sum[0] / 9);
                r.chan1 = 8'(sum[1] / 9);
                r.chan2 = 8'(sum[2] / 9);
            end
            else
            begin
                r.chan0 = centre[7:0];
                r.chan1 = centre[15:8];
                r.chan2 = centre[23:16];
            end
            r.last = (out_row + 1 >= h) && (out_col + 1 >= w);
            expected_pixels.push_back(r);
            if (r.last)
                restart();
            else if (out_col + 1 >= w)
            begin
                out_col = 0;
                out_row++;
            end
            else
                out_col++;
        endfunction

        function void check_result(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                   logic last);
            result_t want;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output pixel: got %02h %02h %02h last=%0b",
                             c0, c1, c2, last);
                return;
            end
            want = expected_pixels.pop_front();
            if (want.chan0 !== c0 || want.chan1 !== c1 || want.chan2 !== c2 ||
                want.last !== last)
            begin
                errors++;
                if (errors <= 10)
                    $display("pixel mismatch: expected %02h %02h %02h last=%0b,",
                             want.chan0, want.chan1, want.chan2, want.last,
                             " got %02h %02h %02h last=%0b", c0, c1, c2, last);
            end
        endfunction
    endclass

    // every input has a known value from time zero
    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cfg_write  = 1'b0;
    logic             cfg_index  = REG_WIDTH;
    logic [CFG_W-1:0] cfg_data   = '0;
    logic             push       = 1'b0;
    logic             full;
    logic             operation  = OP_PIXEL;
    logic [7:0]       chan0_in   = '0;
    logic [7:0]       chan1_in   = '0;
    logic [7:0]       chan2_in   = '0;
    logic             empty;
    logic             pop        = 1'b0;
    logic [7:0]       chan0_out;
    logic [7:0]       chan1_out;
    logic [7:0]       chan2_out;
    logic             frame_last;

    blur_checker chk;
    int unsigned items_sent;       // counted items of the random part
    int unsigned burst_left = 0;   // items left in the current sender burst
    int unsigned quiet_cycles = 0;
    bit          hold_req = 1'b0;  // sender asks the receiver for a long hold-off

    box_blur_3x3_rgb u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sender side. Inputs change on the falling edge; an item counts as
    // taken on the rising edge that sees push high and full low. Items go
    // out in bursts of random length separated by short random gaps, and
    // a quarter of burst boundaries have no gap at all.
    // ------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [7:0] c0, input logic [7:0] c1,
                             input logic [7:0] c2);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        push      <= 1'b1;
        operation <= op;
        chan0_in  <= c0;
        chan1_in  <= c1;
        chan2_in  <= c2;
        @(posedge clk);
        while (full)
            @(posedge clk);
        chk.take_item(op, c0, c1, c2);
    endtask

    // Drop push and wait for every expected pixel, then let the tail of the
    // pipeline (drain ticks and early pixels carry no output) run dry.
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (chk.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both size registers back to back, in random order, while idle.
    task automatic configure(input logic [CFG_W-1:0] wd, input logic [CFG_W-1:0] hd);
        logic first_idx;
        logic second_idx;
        settle();
        first_idx  = $urandom_range(0, 1) ? REG_HEIGHT : REG_WIDTH;
        second_idx = (first_idx == REG_HEIGHT) ? REG_WIDTH : REG_HEIGHT;
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= first_idx;
        cfg_data  <= (first_idx == REG_HEIGHT) ? hd : wd;
        @(posedge clk);
        chk.write_reg(first_idx, (first_idx == REG_HEIGHT) ? hd : wd);
        @(negedge clk);
        cfg_index <= second_idx;
        cfg_data  <= (second_idx == REG_HEIGHT) ? hd : wd;
        @(posedge clk);
        chk.write_reg(second_idx, (second_idx == REG_HEIGHT) ? hd : wd);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Pixel byte styles: plain random, rails only, near full scale (pushes the
    // 3x3 sum towards its 2295 ceiling), or a mix of rails and random.
    function automatic logic [7:0] pick_byte(int flavour);
        case (flavour)
            1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2:       return 8'($urandom_range(240, 255));
            3:       return $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                                 : 8'($urandom);
            default: return 8'($urandom);
        endcase
    endfunction

    // One frame of w x h pixels and then w+1 drain ticks. A cut below w*h
    // abandons the frame part-way; the caller must reconfigure after that.
    // With noise, stray drain ticks land inside the pixel run and stray
    // pixels inside the drain run; the block ignores both.
    task automatic run_frame(input int unsigned w, input int unsigned h,
                             input int unsigned cut, input bit noisy, input int flavour);
        int unsigned total;
        total = w * h;
        for (int unsigned i = 0; i < total && i < cut; i++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
            send_item(OP_PIXEL, pick_byte(flavour), pick_byte(flavour), pick_byte(flavour));
            items_sent++;
        end
        if (cut < total)
            return;
        for (int unsigned i = 0; i <= w; i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_item(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
            // drain ticks carry junk channel bytes, which must not matter
            send_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
            items_sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: pop decided on the falling edge, result taken and
    // checked on the rising edge. The stall pattern switches between
    // always ready, coin toss, mostly stalled and a fixed duty cycle; a
    // hold request from the sender forces a long hold-off so both queues
    // fill and full rises.
    // ------------------------------------------------------------------
    initial
    begin : result_side
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned phase;
        logic        take;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            phase = (phase + 1) % 11;
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else
            begin
                case (mode)
                    0:       take = 1'b1;
                    1:       take = 1'($urandom_range(0, 1));
                    2:       take = ($urandom_range(0, 5) == 0);
                    default: take = (phase < 3);
                endcase
            end
            pop <= take;
            @(posedge clk);
            if (pop && !empty)
                chk.check_result(chan0_out, chan1_out, chan2_out, frame_last);
        end
    end

    // Watchdog: ends the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned w, h, cut;
        logic [CFG_W-1:0] wd, hd;
        bit   reconfig;
        bit   abandoned;
        chk = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset sizes (512 x 512): a part frame long enough to release
        // some of the first row, then abandoned by the next write.
        for (int i = 0; i < 530; i++)
            send_item(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));

        // Directed: smallest frame, all full scale, so the single interior
        // pixel sees the largest possible sum. An early drain tick and a
        // pixel among the drains are both ignored.
        configure(CFG_W'(3), CFG_W'(3));
        for (int i = 0; i < 9; i++)
        begin
            send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
            if (i == 3)
                send_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
        end
        for (int i = 0; i < 4; i++)
        begin
            send_item(OP_DRAIN, 8'hFF, 8'h00, 8'hFF);
            if (i == 1)
                send_item(OP_PIXEL, 8'hA5, 8'h5A, 8'hC3);
        end
        // second frame straight after frame_last, no reconfiguration
        for (int i = 0; i < 9; i++)
            send_item(OP_PIXEL, PATTERN[i], ~PATTERN[i], PATTERN[8 - i]);
        for (int i = 0; i < 4; i++)
            send_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);

        // Random part: mostly complete small frames with random contents,
        // some run back to back, a few abandoned, sizes below 3 included
        // so that clamping is exercised. Width writes carry junk above bit 10.
        items_sent = 0;
        abandoned  = 1'b1;
        w = 3;
        h = 3;
        while (items_sent < RANDOM_ITEMS)
        begin
            reconfig = abandoned || $urandom_range(0, 2) != 0;
            if (reconfig)
            begin
                case ($urandom_range(0, 9))
                    0:       w = $urandom_range(0, 2);
                    1:       w = $urandom_range(13, 40);
                    default: w = $urandom_range(3, 12);
                endcase
                h  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                 : $urandom_range(3, 8);
                wd = {2'($urandom), 11'(w)};
                hd = CFG_W'(h);
                configure(wd, hd);
                w = blur_checker::clamp_dim(w, MAX_WIDTH);
                h = blur_checker::clamp_dim(h, MAX_HEIGHT);
                if (items_sent == 0)
                    hold_req = 1'b1;
            end
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h - 1) : w * h;
            abandoned = (cut < w * h);
            run_frame(w, h, cut, 1'b1, $urandom_range(0, 3));
        end

        // wind down: every expected pixel out, then a quiet tail
        @(negedge clk);
        push <= 1'b0;
        while (chk.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (chk.errors == 0 && chk.expected_pixels.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

@@ files.f @@
rtl/bb3_pkg.sv
rtl/bb3_front.sv
rtl/bb3_queue.sv
rtl/bb3_back.sv
rtl/box_blur_3x3_rgb.sv
dv/box_blur_3x3_rgb_tb.sv
